### rtl/ssr_pkg.sv
// Shared types, constants and helpers for the stream search-and-replace block.
package ssr_pkg;

	localparam int PAT_MAX     = 8;
	localparam int REPL_MAX    = 8;
	localparam int QUEUE_DEPTH = (PAT_MAX > REPL_MAX) ? PAT_MAX : REPL_MAX;
	localparam int CNT_W       = $clog2(PAT_MAX + 1);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W       = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int TALLY_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH     = 3'd0,
		REG_PATTERN_BYTES      = 3'd1,
		REG_REPLACEMENT_LENGTH = 3'd2,
		REG_REPLACEMENT_BYTES  = 3'd3,
		REG_FOLD_CASE          = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       char_present;
		logic       string_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]         char_out;
		logic               char_out_valid;
		logic               string_done;
		logic               run_last;
		logic [TALLY_W-1:0] replace_count;
	} out_word_t;

	// window cell control: take the new character, or take the neighbor's byte
	typedef struct packed {
		logic load;
		logic pop;
	} win_ctrl_t;

	// output queue cell control: load a fresh burst, or advance toward the head
	typedef struct packed {
		logic load;
		logic shift;
	} q_ctrl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
		if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] eff_pat_len(input logic [LEN_W-1:0] len);
		if (len == '0) begin
			return CNT_W'(1);
		end
		if (32'(len) > PAT_MAX) begin
			return CNT_W'(PAT_MAX);
		end
		return CNT_W'(len);
	endfunction

	function automatic logic [QCNT_W-1:0] eff_repl_len(input logic [LEN_W-1:0] len);
		if (32'(len) > REPL_MAX) begin
			return QCNT_W'(REPL_MAX);
		end
		return QCNT_W'(len);
	endfunction

endpackage

### rtl/ssr_win_cell.sv
// One byte of the pending window: storage, neighbor shift and pattern compare.
module ssr_win_cell (
	input  logic              clk,
	input  ssr_pkg::win_ctrl_t ctrl,
	input  logic [7:0]        char_new,
	input  logic [7:0]        nbr_cur,
	input  logic [7:0]        pat_byte,
	input  logic              fold_en,
	output logic [7:0]        cur,
	output logic              eq
);
	import ssr_pkg::*;

	logic [7:0] byte_q;

	// the byte this cell holds once the incoming character is placed
	assign cur = ctrl.load ? char_new : byte_q;
	assign eq  = (fold_byte(cur, fold_en) == fold_byte(pat_byte, fold_en));

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			byte_q <= nbr_cur;
		end else if (ctrl.load) begin
			byte_q <= char_new;
		end
	end

endmodule

### rtl/ssr_out_cell.sv
// One entry of the output queue; advances toward the head as words are taken.
module ssr_out_cell (
	input  logic            clk,
	input  ssr_pkg::q_ctrl_t ctrl,
	input  logic [7:0]      src,
	input  logic [7:0]      nbr,
	output logic [7:0]      q
);
	import ssr_pkg::*;

	logic [7:0] byte_q;

	assign q = byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= src;
		end else if (ctrl.shift) begin
			byte_q <= nbr;
		end
	end

endmodule

### rtl/stream_search_replace_top.sv
// Top level of the stream search-and-replace block.
// Usage:
//   Input words arrive on in_valid/in_ready, one character each, with
//   char_present (the character is real) and string_last (end of string).
//   Result words leave on out_valid/out_ready. Each input word yields zero
//   to eight result words; run_last marks the last one of a word, and the
//   last result of a string carries string_done and the replacement count.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle; a pattern_length write drops the pending window.
// Timing and throughput:
//   The first result of a word shows at out_data in the cycle after the word
//   is accepted. The output queue holds one word's burst and hands out one
//   result per cycle while out_ready is high; a new input word is taken in
//   the cycle its last result leaves. Words with at most one result stream
//   at one per cycle while out_ready is high.
// Reset:
//   arst_n clears the counts and the queue and restores the register
//   defaults (pattern length 1, empty replacement, exact compare).
// Stall:
//   While out_ready is low with a result pending, the head result holds and in_ready stays low.
module stream_search_replace_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ssr_pkg::in_word_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ssr_pkg::out_word_t                 out_data,
	input  logic                               cfg_wr_en,
	input  logic [ssr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ssr_pkg::*;

	// configuration registers
	logic [LEN_W-1:0]      pat_len_q;
	logic [CFG_DATA_W-1:0] pat_bytes_q;
	logic [LEN_W-1:0]      repl_len_q;
	logic [CFG_DATA_W-1:0] repl_bytes_q;
	logic                  fold_q;

	// window and string state
	logic [CNT_W-1:0]   win_cnt_q;
	logic [TALLY_W-1:0] tally_q;

	// output queue state
	logic [QCNT_W-1:0]  qcnt_q;
	logic               q_chars_q;
	logic               q_done_q;
	logic [TALLY_W-1:0] q_tally_q;

	logic               accept;
	logic               take;
	logic [CNT_W-1:0]   plen;
	logic [QCNT_W-1:0]  rlen;
	logic [CNT_W-1:0]   cnt_new;
	logic               full;
	logic               all_eq;
	logic               match;
	logic [QCNT_W-1:0]  burst_len;
	logic [QCNT_W-1:0]  job_len;
	logic [TALLY_W-1:0] tally_new;

	logic [7:0]         win_cur [PAT_MAX];
	logic [PAT_MAX-1:0] win_eq;
	logic [7:0]         q_byte [QUEUE_DEPTH];
	win_ctrl_t          win_ctrl [PAT_MAX];
	q_ctrl_t            q_ctrl;

	cfg_reg_t cfg_reg;

	assign cfg_reg = cfg_reg_t'(cfg_index);

	assign out_valid = (qcnt_q != '0);
	assign take      = out_valid && out_ready;
	// accept while the queue is empty or its final word leaves this cycle
	assign in_ready  = (qcnt_q == '0) || (qcnt_q == QCNT_W'(1) && out_ready);
	assign accept    = in_valid && in_ready;

	assign plen    = eff_pat_len(pat_len_q);
	assign rlen    = eff_repl_len(repl_len_q);
	assign cnt_new = win_cnt_q + CNT_W'(in_data.char_present);
	assign full    = in_data.char_present && (cnt_new == plen);

	// AND the per-cell compares over the cells in use
	always_comb begin
		all_eq = 1'b1;
		for (int i = 0; i < PAT_MAX; i++) begin
			if (CNT_W'(i) < plen) begin
				all_eq = all_eq & win_eq[i];
			end
		end
	end

	assign match = full && all_eq;

	// characters emitted: replacement on a hit, whole window on a flush,
	// the oldest byte when a full window misses
	always_comb begin
		if (match) begin
			burst_len = rlen;
		end else if (in_data.string_last) begin
			burst_len = QCNT_W'(cnt_new);
		end else if (full) begin
			burst_len = QCNT_W'(1);
		end else begin
			burst_len = '0;
		end
	end

	// an end of string with nothing to emit still reports once
	assign job_len = (burst_len != '0) ? burst_len :
		(in_data.string_last ? QCNT_W'(1) : '0);

	assign tally_new = (match && tally_q != {TALLY_W{1'b1}}) ? tally_q + TALLY_W'(1) : tally_q;

	// window cells
	for (genvar i = 0; i < PAT_MAX; i++) begin : g_win
		logic [7:0] nbr;
		if (i == PAT_MAX - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = win_cur[i+1];
		end

		assign win_ctrl[i].load = accept && in_data.char_present && (win_cnt_q == CNT_W'(i));
		assign win_ctrl[i].pop  = accept && full && !match && !in_data.string_last;

		ssr_win_cell u_cell (
			.clk      (clk),
			.ctrl     (win_ctrl[i]),
			.char_new (in_data.char_in),
			.nbr_cur  (nbr),
			.pat_byte (pat_bytes_q[8*i +: 8]),
			.fold_en  (fold_q),
			.cur      (win_cur[i]),
			.eq       (win_eq[i])
		);
	end

	// output queue cells
	assign q_ctrl.load  = accept && (job_len != '0);
	assign q_ctrl.shift = take;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
		logic [7:0] src;
		logic [7:0] nbr;
		logic [7:0] win_src;
		if (i < PAT_MAX) begin : g_w
			assign win_src = win_cur[i];
		end else begin : g_nw
			assign win_src = '0;
		end
		if (i < REPL_MAX) begin : g_r
			assign src = match ? repl_bytes_q[8*i +: 8] : win_src;
		end else begin : g_nr
			assign src = match ? 8'h00 : win_src;
		end
		if (i == QUEUE_DEPTH - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = q_byte[i+1];
		end

		ssr_out_cell u_cell (
			.clk  (clk),
			.ctrl (q_ctrl),
			.src  (src),
			.nbr  (nbr),
			.q    (q_byte[i])
		);
	end

	// head of the queue drives the result word
	always_comb begin
		out_data                = '0;
		out_data.char_out       = q_chars_q ? q_byte[0] : 8'h00;
		out_data.char_out_valid = q_chars_q;
		out_data.run_last       = (qcnt_q == QCNT_W'(1));
		out_data.string_done    = (qcnt_q == QCNT_W'(1)) && q_done_q;
		out_data.replace_count  = out_data.string_done ? q_tally_q : '0;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q    <= LEN_W'(1);
			pat_bytes_q  <= '0;
			repl_len_q   <= '0;
			repl_bytes_q <= '0;
			fold_q       <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg)
				REG_PATTERN_LENGTH:     pat_len_q    <= cfg_wdata[LEN_W-1:0];
				REG_PATTERN_BYTES:      pat_bytes_q  <= cfg_wdata;
				REG_REPLACEMENT_LENGTH: repl_len_q   <= cfg_wdata[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  repl_bytes_q <= cfg_wdata;
				REG_FOLD_CASE:          fold_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// window fill count and replacement tally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
			tally_q   <= '0;
		end else if (cfg_wr_en && cfg_reg == REG_PATTERN_LENGTH) begin
			win_cnt_q <= '0;
		end else if (accept) begin
			if (in_data.string_last || match) begin
				win_cnt_q <= '0;
			end else if (full) begin
				win_cnt_q <= cnt_new - CNT_W'(1);
			end else begin
				win_cnt_q <= cnt_new;
			end
			tally_q <= in_data.string_last ? '0 : tally_new;
		end
	end

	// queue occupancy and burst flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q    <= '0;
			q_chars_q <= 1'b0;
			q_done_q  <= 1'b0;
			q_tally_q <= '0;
		end else if (q_ctrl.load) begin
			qcnt_q    <= job_len;
			q_chars_q <= (burst_len != '0);
			q_done_q  <= in_data.string_last;
			q_tally_q <= tally_new;
		end else if (take) begin
			qcnt_q <= qcnt_q - QCNT_W'(1);
		end
	end

endmodule

### rtl/ssr_checker.sv
// Port-level checks for the stream search-and-replace block, bound to the top.
module ssr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input ssr_pkg::out_word_t out_data
);
	import ssr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_done |-> out_data.run_last)
		else $error("string end not on last result of its word");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.string_done |-> out_data.replace_count == '0)
		else $error("replacement count outside string end");

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_out_valid |-> out_data.string_done && out_data.char_out == 8'h00)
		else $error("empty result that is not a string end");

endmodule

bind stream_search_replace_top ssr_checker u_ssr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
